>>> src/ccomp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccomp_pkg: shared types and helpers for the climate sensor compensation
// Step codes, controller/datapath command structs, arithmetic helpers.
// ----------------------------------------------------------------------------
package ccomp_pkg;

   localparam logic [1:0] CMD_TEMP  = 2'd0;
   localparam logic [1:0] CMD_PRESS = 2'd1;
   localparam logic [1:0] CMD_HUM   = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [2:0] CSR_CAL_TEMP       = 3'd0;
   localparam logic [2:0] CSR_CAL_PRESS_LOW  = 3'd1;
   localparam logic [2:0] CSR_CAL_PRESS_HIGH = 3'd2;
   localparam logic [2:0] CSR_CAL_PRESS_LAST = 3'd3;
   localparam logic [2:0] CSR_CAL_HUM_A      = 3'd4;
   localparam logic [2:0] CSR_CAL_HUM_B      = 3'd5;

   localparam int CSR_DATA_W = 64;
   localparam int DIV_STEPS  = 32;

   typedef enum logic [4:0] {
      S_T0, S_T1, S_T2, S_T3, S_T4,
      S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
      S_P11, S_P12, S_P13, S_P14, S_P15,
      S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_H9, S_H10
   } step_type;

   typedef struct packed {
      logic     load;
      logic     exec;
      step_type step;
      logic     div_start;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic div_zero;
   } ctrl_sts_type;

   function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
      asr32 = $unsigned($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      mul32 = p[31:0];
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

endpackage

>>> src/ccomp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccomp_if: request and response channel interfaces
// Valid/ready channels carrying the raw reading and the compensated value.
// ----------------------------------------------------------------------------
interface ccomp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] reg_msb;
   logic [7:0] reg_lsb;
   logic [7:0] reg_xlsb;

   modport source (output valid, cmd, reg_msb, reg_lsb, reg_xlsb, input ready);
   modport sink   (input valid, cmd, reg_msb, reg_lsb, reg_xlsb, output ready);
endinterface

interface ccomp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] reading;
   logic [1:0]         kind;

   modport source (output valid, reading, kind, input ready);
   modport sink   (input valid, reading, kind, output ready);
endinterface

>>> src/ccomp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccomp_div: unsigned 32/32 divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccomp_div import ccomp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] div_ff, div_in;
   logic [32:0] rem_sh;
   logic [32:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_sh  = {rem_ff, quo_ff[31]};
      diff    = rem_sh - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> src/ccomp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccomp_dp: compensation datapath
// Calibration registers, temporaries, shared multiplier and the divider.
// ----------------------------------------------------------------------------
module ccomp_dp import ccomp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output ctrl_sts_type          sts,
   input  logic [1:0]            in_cmd,
   input  logic [7:0]            in_msb,
   input  logic [7:0]            in_lsb,
   input  logic [7:0]            in_xlsb,
   output logic [31:0]           out_reading,
   output logic [1:0]            out_kind,
   input  logic                  csr_we,
   input  logic [2:0]            csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_low_ff, cal_press_high_ff;
   logic [15:0] cal_press_last_ff;
   logic [47:0] cal_hum_a_ff;
   logic [23:0] cal_hum_b_ff;

   logic [31:0] fine_ff, fine_in;
   logic [31:0] adc_ff, adc_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] res_ff, res_in;
   logic        big_ff, big_in;
   logic [31:0] r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in;
   logic [31:0] r3_ff, r3_in, r4_ff, r4_in, r5_ff, r5_in;
   logic [31:0] tmp;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;

   logic        div_done;
   logic [31:0] div_quo;
   logic [31:0] div_dividend;

   assign t1 = {16'd0, cal_temp_ff[15:0]};
   assign t2 = sx16(cal_temp_ff[31:16]);
   assign t3 = sx16(cal_temp_ff[47:32]);
   assign p1 = {16'd0, cal_press_low_ff[15:0]};
   assign p2 = sx16(cal_press_low_ff[31:16]);
   assign p3 = sx16(cal_press_low_ff[47:32]);
   assign p4 = sx16(cal_press_low_ff[63:48]);
   assign p5 = sx16(cal_press_high_ff[15:0]);
   assign p6 = sx16(cal_press_high_ff[31:16]);
   assign p7 = sx16(cal_press_high_ff[47:32]);
   assign p8 = sx16(cal_press_high_ff[63:48]);
   assign p9 = sx16(cal_press_last_ff);
   assign h1 = {24'd0, cal_hum_a_ff[7:0]};
   assign h2 = sx16(cal_hum_a_ff[23:8]);
   assign h3 = {24'd0, cal_hum_a_ff[31:24]};
   assign h4 = sx16(cal_hum_a_ff[47:32]);
   assign h5 = sx16(cal_hum_b_ff[15:0]);
   assign h6 = {{24{cal_hum_b_ff[23]}}, cal_hum_b_ff[23:16]};

   assign div_dividend = r1_ff[31] ? r1_ff : {r1_ff[30:0], 1'b0};

   ccomp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (r0_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign sts.div_done = div_done;
   assign sts.div_zero = (r0_ff == 32'd0);

   always_comb begin
      fine_in = fine_ff;
      adc_in  = adc_ff;
      kind_in = kind_ff;
      res_in  = res_ff;
      big_in  = big_ff;
      r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff;
      r3_in = r3_ff; r4_in = r4_ff; r5_in = r5_ff;
      tmp = '0;
      if (cmd.load) begin
         kind_in = in_cmd;
         if (in_cmd == CMD_HUM) begin
            adc_in = {16'd0, in_msb, in_lsb};
         end else begin
            adc_in = {12'd0, in_msb, in_lsb, in_xlsb[7:4]};
         end
      end else if (cmd.exec) begin
         unique case (cmd.step)
            // temperature
            S_T0: begin
               r0_in = asr32(adc_ff, 3) - {t1[30:0], 1'b0};
               r1_in = asr32(adc_ff, 4) - t1;
            end
            S_T1: r0_in = asr32(mul32(r0_ff, t2), 11);
            S_T2: r1_in = asr32(mul32(r1_ff, r1_ff), 12);
            S_T3: r1_in = asr32(mul32(r1_ff, t3), 14);
            S_T4: begin
               tmp     = r0_ff + r1_ff;
               fine_in = tmp;
               res_in  = asr32({tmp[29:0], 2'b00} + tmp + 32'd128, 8);
            end
            // pressure
            S_P0: begin
               tmp   = asr32(fine_ff, 1) - 32'd64000;
               r0_in = tmp;
               r1_in = asr32(tmp, 2);
            end
            S_P1: r2_in = mul32(r1_ff, r1_ff);
            S_P2: r3_in = mul32(asr32(r2_ff, 11), p6);
            S_P3: begin
               tmp   = mul32(r0_ff, p5);
               r4_in = {tmp[30:0], 1'b0};
            end
            S_P4: r3_in = asr32(r3_ff + r4_ff, 2) + {p4[15:0], 16'd0};
            S_P5: r4_in = mul32(p3, asr32(r2_ff, 13));
            S_P6: r5_in = mul32(p2, r0_ff);
            S_P7: r0_in = asr32(asr32(r4_ff, 3) + asr32(r5_ff, 1), 18);
            S_P8: r0_in = asr32(mul32(32'd32768 + r0_ff, p1), 15);
            S_P9: r1_in = mul32((32'd1048576 - adc_ff) - asr32(r3_ff, 12), 32'd3125);
            S_P10: begin
               big_in = r1_ff[31];
               if (r0_ff == 32'd0) res_in = '0;
            end
            S_P11: r1_in = big_ff ? {div_quo[30:0], 1'b0} : div_quo;
            S_P12: r2_in = mul32({3'd0, r1_ff[31:3]}, {3'd0, r1_ff[31:3]});
            S_P13: r2_in = asr32(mul32(p9, {13'd0, r2_ff[31:13]}), 12);
            S_P14: r3_in = asr32(mul32({2'd0, r1_ff[31:2]}, p8), 13);
            S_P15: res_in = r1_ff + asr32(r2_ff + r3_ff + p7, 4);
            // humidity
            S_H0: r0_in = fine_ff - 32'd76800;
            S_H1: r1_in = mul32(h5, r0_ff);
            S_H2: r1_in = asr32({adc_ff[17:0], 14'd0} - {h4[11:0], 20'd0} - r1_ff
                                + 32'd16384, 15);
            S_H3: r2_in = asr32(mul32(r0_ff, h6), 10);
            S_H4: r3_in = asr32(mul32(r0_ff, h3), 11) + 32'd32768;
            S_H5: r2_in = asr32(mul32(r2_ff, r3_ff), 10) + 32'd2097152;
            S_H6: r2_in = asr32(mul32(r2_ff, h2) + 32'd8192, 14);
            S_H7: r0_in = mul32(r1_ff, r2_ff);
            S_H8: r3_in = asr32(mul32(asr32(r0_ff, 15), asr32(r0_ff, 15)), 7);
            S_H9: r3_in = r0_ff - asr32(mul32(r3_ff, h1), 4);
            S_H10: begin
               if (r3_ff[31]) tmp = '0;
               else if (r3_ff > 32'd419430400) tmp = 32'd419430400;
               else tmp = r3_ff;
               res_in = {12'd0, tmp[31:12]};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff       <= '0;
         cal_press_low_ff  <= '0;
         cal_press_high_ff <= '0;
         cal_press_last_ff <= '0;
         cal_hum_a_ff      <= '0;
         cal_hum_b_ff      <= '0;
         fine_ff           <= '0;
      end else begin
         fine_ff <= fine_in;
         if (csr_we) begin
            unique case (csr_idx)
               CSR_CAL_TEMP:       cal_temp_ff       <= csr_wdata[47:0];
               CSR_CAL_PRESS_LOW:  cal_press_low_ff  <= csr_wdata;
               CSR_CAL_PRESS_HIGH: cal_press_high_ff <= csr_wdata;
               CSR_CAL_PRESS_LAST: cal_press_last_ff <= csr_wdata[15:0];
               CSR_CAL_HUM_A:      cal_hum_a_ff      <= csr_wdata[47:0];
               CSR_CAL_HUM_B:      cal_hum_b_ff      <= csr_wdata[23:0];
               default: ;
            endcase
         end
      end
      adc_ff  <= adc_in;
      kind_ff <= kind_in;
      res_ff  <= res_in;
      big_ff  <= big_in;
      r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in;
      r3_ff <= r3_in; r4_ff <= r4_in; r5_ff <= r5_in;
   end

   assign out_reading = res_ff;
   assign out_kind    = kind_ff;
endmodule

>>> src/ccomp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccomp_ctrl: compensation sequencer
// Walks the datapath through the steps of one reading kind.
// ----------------------------------------------------------------------------
module ccomp_ctrl import ccomp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [1:0]   in_cmd,
   output logic         out_valid,
   input  logic         out_ready,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);
   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_OUT} state_type;

   state_type state_ff;
   step_type  step_ff;
   logic      accept;
   logic      last_step;
   logic      zero_exit;

   assign accept    = in_valid && (state_ff == ST_IDLE);
   assign last_step = (step_ff == S_T4) || (step_ff == S_P15) || (step_ff == S_H10);
   assign zero_exit = (step_ff == S_P10) && sts.div_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= S_T0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  unique case (in_cmd)
                     CMD_TEMP:  begin step_ff <= S_T0; state_ff <= ST_RUN; end
                     CMD_PRESS: begin step_ff <= S_P0; state_ff <= ST_RUN; end
                     CMD_HUM:   begin step_ff <= S_H0; state_ff <= ST_RUN; end
                     default:   state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_RUN: begin
               if (last_step || zero_exit) begin
                  state_ff <= ST_OUT;
               end else if (step_ff == S_P10) begin
                  state_ff <= ST_DIV;
               end else begin
                  step_ff <= step_type'(step_ff + 5'd1);
               end
            end
            ST_DIV: begin
               if (sts.div_done) begin
                  step_ff  <= S_P11;
                  state_ff <= ST_RUN;
               end
            end
            ST_OUT: begin
               if (out_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign in_ready      = (state_ff == ST_IDLE);
   assign out_valid     = (state_ff == ST_OUT);
   assign cmd.load      = accept;
   assign cmd.exec      = (state_ff == ST_RUN);
   assign cmd.step      = step_ff;
   assign cmd.div_start = (state_ff == ST_RUN) && (step_ff == S_P10) && !sts.div_zero;
endmodule

>>> src/climate_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_sensor_compensation: integer compensation of raw sensor readings
// Converts raw temperature, pressure and humidity samples with calibration.
// ----------------------------------------------------------------------------
// usage
//  - req_chan carries one raw reading (kind plus three register bytes) per
//    transaction; rsp_chan returns the compensated value and the echoed kind
//  - kind 3 is accepted and dropped, no response transaction follows
//  - calibration words are written through csr_we/csr_idx/csr_wdata while
//    the block is idle; indexes above 5 are ignored
//  - one reading is in flight at a time: req ready only in the idle state
//  - the time from accept to rsp valid depends on the kind and is set by the
//    step sequence on the shared multiplier and the bit-per-cycle divider;
//    a pressure reading with a zero divisor skips the divider
//  - a temperature reading stores the fine-temperature term used by later
//    pressure and humidity readings
//  - reset clears calibration, fine temperature and the sequencer
//  - a stalled response holds in the output register until rsp ready;
//    the next request is taken the cycle after the response transaction
// ----------------------------------------------------------------------------
module climate_sensor_compensation import ccomp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ccomp_req_if.sink             req_chan,
   ccomp_rsp_if.source           rsp_chan,
   input  logic                  csr_we,
   input  logic [2:0]            csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   // command and status between sequencer and datapath
   ctrl_cmd_type ctl_cmd;
   ctrl_sts_type ctl_sts;
   logic [31:0]  reading_raw;

   ccomp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_cmd    (req_chan.cmd),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .cmd       (ctl_cmd),
      .sts       (ctl_sts)
   );

   ccomp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ctl_cmd),
      .sts         (ctl_sts),
      .in_cmd      (req_chan.cmd),
      .in_msb      (req_chan.reg_msb),
      .in_lsb      (req_chan.reg_lsb),
      .in_xlsb     (req_chan.reg_xlsb),
      .out_reading (reading_raw),
      .out_kind    (rsp_chan.kind),
      .csr_we      (csr_we),
      .csr_idx     (csr_idx),
      .csr_wdata   (csr_wdata)
   );

   // result register drives the response payload directly
   assign rsp_chan.reading = $signed(reading_raw);

   // never offer a response and take a request at once
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(rsp_chan.valid && req_chan.ready))
      else $error("response pending while request side ready");

   // a response never carries the unused kind
   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.kind != CMD_NONE))
      else $error("response with unused kind");

   // an unused kind is dropped without leaving idle
   a_drop_none: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd == CMD_NONE) |=> req_chan.ready)
      else $error("unused kind did not return to idle");

   // the sequencer starts the divider only on a nonzero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.div_start |-> !ctl_sts.div_zero)
      else $error("divider started with zero divisor");
endmodule
